// ===== design/sbam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbam_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned ADC_W       = 10;
  localparam int unsigned ADC_MAX     = 1023;
  localparam int unsigned TIMER_W     = 22;
  localparam int unsigned DEB_W       = 11;
  localparam int unsigned TICKS_W     = 10;
  localparam int unsigned MARGIN_W    = 14;
  localparam int unsigned DIFF_OUT_W  = 23;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 22;

  localparam logic [TIMER_W-1:0]    TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [DEB_W-1:0]      DEB_MAX   = 11'd1024;
  localparam logic [DIFF_OUT_W-1:0] DIFF_MAX  = {DIFF_OUT_W{1'b1}};

  // Register reset values.
  localparam logic [TIMER_W-1:0]  WARMUP_RST    = 22'd900000;
  localparam logic [TICKS_W-1:0]  DEBOUNCE_RST  = 10'd50;
  localparam logic [TICKS_W-1:0]  INTERVAL_RST  = 10'd10;
  localparam logic [TICKS_W-1:0]  SPACING_RST   = 10'd20;
  localparam int unsigned         ALERT_MARGIN_RST  = 640;
  localparam int unsigned         NORMAL_MARGIN_RST = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARMUP        = 3'd0,
    CFG_DEBOUNCE      = 3'd1,
    CFG_READ_INTERVAL = 3'd2,
    CFG_CALIB_SPACING = 3'd3,
    CFG_ALERT_MARGIN  = 3'd4,
    CFG_NORMAL_MARGIN = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PHASE_OFF  = 2'd0,
    PHASE_WARM = 2'd1,
    PHASE_CAL  = 2'd2,
    PHASE_MEAS = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    LAMP_DARK   = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2,
    LAMP_RED    = 2'd3
  } lamp_e;

  typedef struct packed {
    logic [TIMER_W-1:0] warmup_ticks;
    logic [TICKS_W-1:0] debounce_ticks;
    logic [TICKS_W-1:0] read_interval_ticks;
    logic [TICKS_W-1:0] calib_spacing_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DIFF_OUT_W-1:0] scaled_difference;
    logic                  alert_now;
    logic                  verdict_valid;
    phase_e                run_phase;
    lamp_e                 lamp_code;
  } result_t;

endpackage

`default_nettype wire

// ===== design/sbam_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers. The two margins are stored already multiplied by
// AVG_SAMPLES * CALIB_SAMPLES, which is the only form the comparator needs.
module sbam_cfg_regs #(
  parameter int unsigned AVG_SAMPLES   = 50,
  parameter int unsigned CALIB_SAMPLES = 100,
  localparam int unsigned AC    = AVG_SAMPLES * CALIB_SAMPLES,
  localparam int unsigned AC_W  = $clog2(AC + 1),
  localparam int unsigned THR_W = sbam_pkg::MARGIN_W + AC_W
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [sbam_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  wire logic [sbam_pkg::CFG_DATA_W-1:0] wr_data_i,
  output sbam_pkg::cfg_t                       cfg_o,
  output logic [THR_W-1:0]                     alert_thr_o,
  output logic [THR_W-1:0]                     normal_thr_o
);

  localparam logic [THR_W-1:0] ALERT_THR_RST  = THR_W'(sbam_pkg::ALERT_MARGIN_RST * AC);
  localparam logic [THR_W-1:0] NORMAL_THR_RST = THR_W'(sbam_pkg::NORMAL_MARGIN_RST * AC);

  sbam_pkg::cfg_t     cfg_q;
  logic [THR_W-1:0]   alert_thr_q;
  logic [THR_W-1:0]   normal_thr_q;
  logic [THR_W-1:0]   margin_prod;

  assign margin_prod = THR_W'(wr_data_i[sbam_pkg::MARGIN_W-1:0]) * THR_W'(AC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warmup_ticks        <= sbam_pkg::WARMUP_RST;
      cfg_q.debounce_ticks      <= sbam_pkg::DEBOUNCE_RST;
      cfg_q.read_interval_ticks <= sbam_pkg::INTERVAL_RST;
      cfg_q.calib_spacing_ticks <= sbam_pkg::SPACING_RST;
      alert_thr_q               <= ALERT_THR_RST;
      normal_thr_q              <= NORMAL_THR_RST;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        sbam_pkg::CFG_WARMUP: begin
          cfg_q.warmup_ticks <= wr_data_i[sbam_pkg::TIMER_W-1:0];
        end
        sbam_pkg::CFG_DEBOUNCE: begin
          cfg_q.debounce_ticks <= wr_data_i[sbam_pkg::TICKS_W-1:0];
        end
        sbam_pkg::CFG_READ_INTERVAL: begin
          cfg_q.read_interval_ticks <= wr_data_i[sbam_pkg::TICKS_W-1:0];
        end
        sbam_pkg::CFG_CALIB_SPACING: begin
          cfg_q.calib_spacing_ticks <= wr_data_i[sbam_pkg::TICKS_W-1:0];
        end
        sbam_pkg::CFG_ALERT_MARGIN: begin
          alert_thr_q <= margin_prod;
        end
        sbam_pkg::CFG_NORMAL_MARGIN: begin
          normal_thr_q <= margin_prod;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o        = cfg_q;
  assign alert_thr_o  = alert_thr_q;
  assign normal_thr_o = normal_thr_q;

endmodule

`default_nettype wire

// ===== design/sbam_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick engine: debouncer, phase sequencer, sample accumulator and hysteresis
// comparator. All state advances by one tick when step_i is high.
module sbam_core #(
  parameter int unsigned AVG_SAMPLES   = 50,
  parameter int unsigned CALIB_SAMPLES = 100,
  localparam int unsigned AC     = AVG_SAMPLES * CALIB_SAMPLES,
  localparam int unsigned AC_W   = $clog2(AC + 1),
  localparam int unsigned THR_W  = sbam_pkg::MARGIN_W + AC_W
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       button_level_i,
  input  wire logic [sbam_pkg::ADC_W-1:0] adc_sample_i,
  input  wire sbam_pkg::cfg_t             cfg_i,
  input  wire logic [THR_W-1:0]           alert_thr_i,
  input  wire logic [THR_W-1:0]           normal_thr_i,
  output sbam_pkg::result_t               result_o
);

  localparam int unsigned MAXN   = (AVG_SAMPLES > CALIB_SAMPLES) ? AVG_SAMPLES : CALIB_SAMPLES;
  localparam int unsigned SUM_W  = $clog2(MAXN * sbam_pkg::ADC_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(MAXN + 1);
  localparam int unsigned DIFF_W = $clog2(AC * sbam_pkg::ADC_MAX + 1);
  localparam int unsigned CMP_W  = (DIFF_W + 4 > THR_W) ? DIFF_W + 4 : THR_W;
  localparam int unsigned EXT_W  =
    (DIFF_W > sbam_pkg::DIFF_OUT_W) ? DIFF_W : sbam_pkg::DIFF_OUT_W + 1;
  localparam int unsigned TW     = sbam_pkg::TIMER_W;

  logic                       power_q, power_d;
  sbam_pkg::phase_e           phase_q, phase_d;
  logic                       stable_q, stable_d;
  logic                       prev_q, prev_d;
  logic [sbam_pkg::DEB_W-1:0] deb_q, deb_d;
  logic [TW-1:0]              ptimer_q, ptimer_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [SUM_W-1:0]           base_q, base_d;
  logic                       alert_q, alert_d;
  sbam_pkg::lamp_e            lamp_q, lamp_d;

  logic                              fresh;
  logic                              verdict;
  logic [DIFF_W-1:0]                 prod_a;
  logic [DIFF_W-1:0]                 prod_b;
  logic [DIFF_W-1:0]                 diff;
  logic [CMP_W-1:0]                  diff_x16;
  logic [EXT_W-1:0]                  diff_ext;
  logic [sbam_pkg::TICKS_W-1:0]      spacing;

  always_comb begin
    power_d  = power_q;
    phase_d  = phase_q;
    stable_d = stable_q;
    prev_d   = prev_q;
    deb_d    = deb_q;
    ptimer_d = ptimer_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    base_d   = base_q;
    alert_d  = alert_q;
    lamp_d   = lamp_q;
    fresh    = 1'b0;
    verdict  = 1'b0;
    prod_a   = '0;
    prod_b   = '0;
    diff     = '0;
    diff_x16 = '0;
    spacing  = (cfg_i.calib_spacing_ticks == '0) ? sbam_pkg::TICKS_W'(1)
                                                  : cfg_i.calib_spacing_ticks;

    // The button is only watched outside calibration.
    if (phase_q != sbam_pkg::PHASE_CAL) begin
      if (button_level_i != prev_q) begin
        deb_d = '0;
      end else if (deb_q != sbam_pkg::DEB_MAX) begin
        deb_d = deb_q + 1'b1;
      end
      if (deb_d > sbam_pkg::DEB_W'(cfg_i.debounce_ticks) && button_level_i != stable_q) begin
        stable_d = button_level_i;
        if (!button_level_i) begin
          power_d  = !power_q;
          sum_d    = '0;
          cnt_d    = '0;
          alert_d  = 1'b0;
          ptimer_d = '0;
          if (!power_q) begin
            phase_d = sbam_pkg::PHASE_WARM;
            lamp_d  = sbam_pkg::LAMP_YELLOW;
            fresh   = 1'b1;
          end else begin
            phase_d = sbam_pkg::PHASE_OFF;
            lamp_d  = sbam_pkg::LAMP_DARK;
          end
        end
      end
      prev_d = button_level_i;
    end else if (deb_q != sbam_pkg::DEB_MAX) begin
      deb_d = deb_q + 1'b1;
    end

    if (phase_d == sbam_pkg::PHASE_WARM) begin
      if (!fresh && ptimer_d != sbam_pkg::TIMER_MAX) begin
        ptimer_d = ptimer_d + 1'b1;
      end
      if (ptimer_d >= cfg_i.warmup_ticks) begin
        // First calibration sample is taken on the tick warm-up ends.
        phase_d  = sbam_pkg::PHASE_CAL;
        lamp_d   = sbam_pkg::LAMP_DARK;
        sum_d    = SUM_W'(adc_sample_i);
        cnt_d    = CNT_W'(1);
        ptimer_d = '0;
      end
    end else if (phase_d == sbam_pkg::PHASE_CAL) begin
      if (ptimer_d != sbam_pkg::TIMER_MAX) begin
        ptimer_d = ptimer_d + 1'b1;
      end
      if (ptimer_d >= TW'(spacing)) begin
        ptimer_d = '0;
        if (cnt_d < CNT_W'(CALIB_SAMPLES)) begin
          sum_d = sum_d + SUM_W'(adc_sample_i);
          cnt_d = cnt_d + 1'b1;
        end else begin
          // Baseline is complete; the first measuring sample follows at once.
          base_d   = sum_d;
          sum_d    = '0;
          cnt_d    = '0;
          phase_d  = sbam_pkg::PHASE_MEAS;
          ptimer_d = sbam_pkg::TIMER_MAX;
        end
      end
    end else if (phase_d == sbam_pkg::PHASE_MEAS) begin
      if (ptimer_d != sbam_pkg::TIMER_MAX) begin
        ptimer_d = ptimer_d + 1'b1;
      end
    end

    if (phase_d == sbam_pkg::PHASE_MEAS && ptimer_d >= TW'(cfg_i.read_interval_ticks)) begin
      ptimer_d = '0;
      sum_d    = sum_d + SUM_W'(adc_sample_i);
      cnt_d    = cnt_d + 1'b1;
      if (cnt_d >= CNT_W'(AVG_SAMPLES)) begin
        // Compare the block mean with the baseline by cross-multiplication.
        prod_a   = DIFF_W'(sum_d) * DIFF_W'(CALIB_SAMPLES);
        prod_b   = DIFF_W'(base_d) * DIFF_W'(AVG_SAMPLES);
        diff     = (prod_a >= prod_b) ? prod_a - prod_b : prod_b - prod_a;
        diff_x16 = CMP_W'(diff) << 4;
        if (!alert_q && diff_x16 > CMP_W'(alert_thr_i)) begin
          alert_d = 1'b1;
        end else if (alert_q && diff_x16 < CMP_W'(normal_thr_i)) begin
          alert_d = 1'b0;
        end
        lamp_d  = alert_d ? sbam_pkg::LAMP_RED : sbam_pkg::LAMP_GREEN;
        verdict = 1'b1;
        sum_d   = '0;
        cnt_d   = '0;
      end
    end
  end

  assign diff_ext = EXT_W'(diff);

  always_comb begin
    result_o.lamp_code     = lamp_d;
    result_o.run_phase     = phase_d;
    result_o.verdict_valid = verdict;
    result_o.alert_now     = alert_d;
    if (diff_ext > EXT_W'(sbam_pkg::DIFF_MAX)) begin
      result_o.scaled_difference = sbam_pkg::DIFF_MAX;
    end else begin
      result_o.scaled_difference = diff_ext[sbam_pkg::DIFF_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q  <= 1'b0;
      phase_q  <= sbam_pkg::PHASE_OFF;
      stable_q <= 1'b1;
      prev_q   <= 1'b1;
      deb_q    <= '0;
      ptimer_q <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      base_q   <= '0;
      alert_q  <= 1'b0;
      lamp_q   <= sbam_pkg::LAMP_DARK;
    end else if (step_i) begin
      power_q  <= power_d;
      phase_q  <= phase_d;
      stable_q <= stable_d;
      prev_q   <= prev_d;
      deb_q    <= deb_d;
      ptimer_q <= ptimer_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      base_q   <= base_d;
      alert_q  <= alert_d;
      lamp_q   <= lamp_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/sensor_baseline_alarm_monitor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sensor baseline alarm monitor. Every input transaction is one millisecond
// tick that carries the raw button pin and the current converter sample; every
// tick produces exactly one output transaction with the lamp code, the run
// phase, a verdict flag, the hysteresis alert and, on verdict ticks, the scaled
// distance between the block mean and the calibrated baseline (in units of
// 1/(AVG_SAMPLES*CALIB_SAMPLES) count, saturated to 23 bits). A debounced press
// toggles power; power-on runs warm-up, then calibration, then block
// measurement. The block accepts one tick per clock cycle while results drain;
// each tick waits in the input register, then the single-pass next-state
// logic (debounce, phase timers, accumulator, cross-multiplied compare) loads
// the result register. While a finished result waits for the downstream side,
// the input register still takes one more tick and then holds it until the
// result drains. No clearing pass is needed after reset.
// Configuration writes are taken in any cycle (cfg_ready_o is always high) but
// must only be issued while no tick is in flight; the two margin registers are
// stored premultiplied by AVG_SAMPLES*CALIB_SAMPLES at write time.
module sensor_baseline_alarm_monitor_top #(
  parameter int unsigned AVG_SAMPLES   = 50,
  parameter int unsigned CALIB_SAMPLES = 100
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Tick input. tdata: [0] button_level, [10:1] adc_sample, [15:11] zero.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [sbam_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Tick result. tdata: [1:0] lamp_code, [3:2] run_phase, [4] alert_now,
  // [27:5] scaled_difference, [31:28] zero. tuser: [0] verdict_valid.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [sbam_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser,
  // Register write channel.
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [sbam_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sbam_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned AC    = AVG_SAMPLES * CALIB_SAMPLES;
  localparam int unsigned AC_W  = $clog2(AC + 1);
  localparam int unsigned THR_W = sbam_pkg::MARGIN_W + AC_W;
  localparam int unsigned PAD_W =
    sbam_pkg::OUT_TDATA_W - sbam_pkg::DIFF_OUT_W - 5;

  sbam_pkg::cfg_t              cfg;
  logic [THR_W-1:0]            alert_thr;
  logic [THR_W-1:0]            normal_thr;
  sbam_pkg::result_t           result;

  // Input register.
  logic                        in_vld_q, in_vld_d;
  logic                        in_lvl_q;
  logic [sbam_pkg::ADC_W-1:0]  in_smp_q;
  logic                        in_take;

  // Result register.
  logic                        out_vld_q, out_vld_d;
  sbam_pkg::result_t           out_q;

  // A tick advances when it is held and the result slot is free or draining.
  logic                        advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_lvl_q <= s_axis_tdata[0];
      in_smp_q <= s_axis_tdata[sbam_pkg::ADC_W:1];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  sbam_cfg_regs #(
    .AVG_SAMPLES  (AVG_SAMPLES),
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (cfg_valid_i && cfg_ready_o),
    .wr_idx_i    (cfg_index_i),
    .wr_data_i   (cfg_data_i),
    .cfg_o       (cfg),
    .alert_thr_o (alert_thr),
    .normal_thr_o(normal_thr)
  );

  sbam_core #(
    .AVG_SAMPLES  (AVG_SAMPLES),
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .button_level_i(in_lvl_q),
    .adc_sample_i  (in_smp_q),
    .cfg_i         (cfg),
    .alert_thr_i   (alert_thr),
    .normal_thr_i  (normal_thr),
    .result_o      (result)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q.scaled_difference, out_q.alert_now,
                          out_q.run_phase, out_q.lamp_code};
  assign m_axis_tuser  = out_q.verdict_valid;

endmodule

`default_nettype wire

// ===== design/sbam_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbam_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [sbam_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [sbam_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                             m_axis_tuser,
  input wire logic                             cfg_valid_i,
  input wire logic                             cfg_ready_o,
  input wire logic [sbam_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input wire logic [sbam_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // A verdict only comes out of the measuring phase, with a green or red lamp.
  a_verdict_in_meas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[3:2] == sbam_pkg::PHASE_MEAS &&
      (m_axis_tdata[1:0] == sbam_pkg::LAMP_GREEN || m_axis_tdata[1:0] == sbam_pkg::LAMP_RED))
    else $error("verdict outside measuring phase");

  // Without a verdict the difference field is zero.
  a_diff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[27:5] == '0)
    else $error("difference reported without verdict");

  // An active alert always shows the red lamp.
  a_alert_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[1:0] == sbam_pkg::LAMP_RED)
    else $error("alert without red lamp");

  // When powered off the lamp is dark and no alert is held.
  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:2] == sbam_pkg::PHASE_OFF |->
      m_axis_tdata[1:0] == sbam_pkg::LAMP_DARK && !m_axis_tdata[4])
    else $error("lamp or alert active while off");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind sensor_baseline_alarm_monitor_top sbam_checker u_sbam_checker (.*);

`default_nettype wire

// ===== verif/tb_sensor_baseline_alarm_monitor_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sensor baseline alarm monitor. Millisecond ticks
// are queued by the stimulus process, pushed into the tick stream by a bursty
// driver, and mirrored into a cycle-free model of the monitor. The model's
// status words wait in a queue. The result stream is drained by a monitor
// that stalls in changing patterns. It compares every status transaction
// field by field with the oldest waiting word.
module tb_sensor_baseline_alarm_monitor_top;

  import sbam_pkg::*;

  localparam int unsigned AVG_N       = 50;
  localparam int unsigned CAL_N       = 100;
  localparam int unsigned AC_PRODUCT  = AVG_N * CAL_N;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One millisecond tick as the sender sees it.
  typedef struct packed {
    logic             btn;
    logic [ADC_W-1:0] adc;
  } sensor_tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Tick stream, result stream and register write channel.
  logic                   in_valid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_data   = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_WARMUP;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire                    m_axis_tuser;
  wire                    cfg_ready_o;

  sensor_baseline_alarm_monitor_top #(
    .AVG_SAMPLES   (AVG_N),
    .CALIB_SAMPLES (CAL_N)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Ticks waiting for the driver, and status words waiting for the DUT.
  sensor_tick_t tick_backlog_q[$];
  result_t      pending_status_q[$];
  int unsigned  bad_status_cnt = 0;
  int unsigned  cycle_cnt      = 0;

  // Register copies as the DUT should hold them.
  logic [TIMER_W-1:0]  warm_len;
  logic [TICKS_W-1:0]  deb_len;
  logic [TICKS_W-1:0]  intv_len;
  logic [TICKS_W-1:0]  space_len;
  logic [MARGIN_W-1:0] alert_len;
  logic [MARGIN_W-1:0] normal_len;

  // Monitor state, advanced once per accepted tick.
  logic               pw;
  phase_e             ph;
  logic               stab_btn;
  logic               prev_btn;
  logic [DEB_W-1:0]   deb_cnt;
  logic [TIMER_W-1:0] ph_timer;
  logic [6:0]         smp_cnt;
  logic [16:0]        smp_sum;
  logic [16:0]        base_sum;
  logic               alarm;
  lamp_e              lamp;

  // Stimulus shaping: a slowly wandering converter level.
  int          adc_center = 512;
  int unsigned adc_hold   = 0;

  // Sender burst shaping and receiver stall shaping.
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_len  = 0;

  // Computes the status word of one tick and moves the monitor state on.
  // The button is blind during calibration, where only the debounce timer
  // keeps running.
  function automatic result_t advance_monitor_tick(input logic btn,
                                                   input logic [ADC_W-1:0] adc);
    result_t           r;
    logic              fresh;
    logic              verdict;
    logic [TICKS_W-1:0] spacing;
    longint unsigned   a;
    longint unsigned   b;
    longint unsigned   d;
    fresh   = 1'b0;
    verdict = 1'b0;
    d       = 0;
    if (ph != PHASE_CAL) begin
      if (btn != prev_btn) begin
        deb_cnt = '0;
      end else if (deb_cnt < DEB_MAX) begin
        deb_cnt = deb_cnt + 1'b1;
      end
      if (deb_cnt > deb_len && btn != stab_btn) begin
        stab_btn = btn;
        if (!btn) begin
          pw       = !pw;
          smp_sum  = '0;
          smp_cnt  = '0;
          alarm    = 1'b0;
          ph_timer = '0;
          if (pw) begin
            ph    = PHASE_WARM;
            lamp  = LAMP_YELLOW;
            fresh = 1'b1;
          end else begin
            ph   = PHASE_OFF;
            lamp = LAMP_DARK;
          end
        end
      end
      prev_btn = btn;
    end else if (deb_cnt < DEB_MAX) begin
      deb_cnt = deb_cnt + 1'b1;
    end

    case (ph)
      PHASE_WARM: begin
        if (!fresh && ph_timer != '1) ph_timer = ph_timer + 1'b1;
        if (ph_timer >= warm_len) begin
          ph       = PHASE_CAL;
          lamp     = LAMP_DARK;
          smp_sum  = 17'(adc);
          smp_cnt  = 7'd1;
          ph_timer = '0;
        end
      end
      PHASE_CAL: begin
        spacing = (space_len == '0) ? TICKS_W'(1) : space_len;
        if (ph_timer != '1) ph_timer = ph_timer + 1'b1;
        if (ph_timer >= spacing) begin
          ph_timer = '0;
          if (smp_cnt < CAL_N) begin
            smp_sum = smp_sum + adc;
            smp_cnt = smp_cnt + 1'b1;
          end else begin
            // Baseline done: the first block sample is due on this tick.
            base_sum = smp_sum;
            smp_sum  = '0;
            smp_cnt  = '0;
            ph       = PHASE_MEAS;
            ph_timer = '1;
          end
        end
      end
      PHASE_MEAS: begin
        if (ph_timer != '1) ph_timer = ph_timer + 1'b1;
      end
      default: begin
      end
    endcase

    if (ph == PHASE_MEAS && ph_timer >= intv_len) begin
      ph_timer = '0;
      smp_sum  = smp_sum + adc;
      smp_cnt  = smp_cnt + 1'b1;
      if (smp_cnt >= AVG_N) begin
        // Mean versus baseline, cross-multiplied so no division is needed.
        a = longint'(smp_sum) * CAL_N;
        b = longint'(base_sum) * AVG_N;
        d = (a >= b) ? a - b : b - a;
        if (!alarm && d * 16 > longint'(alert_len) * AC_PRODUCT) begin
          alarm = 1'b1;
        end else if (alarm && d * 16 < longint'(normal_len) * AC_PRODUCT) begin
          alarm = 1'b0;
        end
        lamp    = alarm ? LAMP_RED : LAMP_GREEN;
        verdict = 1'b1;
        smp_sum = '0;
        smp_cnt = '0;
      end
    end

    r.lamp_code         = lamp;
    r.run_phase         = ph;
    r.verdict_valid     = verdict;
    r.alert_now         = alarm;
    r.scaled_difference = !verdict ? '0 :
                          (d > longint'(DIFF_MAX)) ? DIFF_MAX : DIFF_OUT_W'(d);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      bad_status_cnt++;
    end
  endfunction

  // Converter level that holds a center for a while and then jumps, so that
  // block means drift away from the baseline and come back.
  function automatic logic [ADC_W-1:0] next_adc();
    int v;
    if (adc_hold == 0) begin
      case ($urandom_range(0, 9))
        0:       adc_center = 0;
        1:       adc_center = ADC_MAX;
        default: adc_center = $urandom_range(0, ADC_MAX);
      endcase
      adc_hold = $urandom_range(10, 80);
    end
    adc_hold--;
    if ($urandom_range(0, 99) < 3) return ADC_W'($urandom_range(0, ADC_MAX));
    v = adc_center + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > int'(ADC_MAX)) v = ADC_MAX;
    return ADC_W'(v);
  endfunction

  task automatic push_tick(input logic btn, input logic [ADC_W-1:0] adc);
    sensor_tick_t t;
    t.btn = btn;
    t.adc = adc;
    tick_backlog_q.push_back(t);
  endtask

  // A press held just long enough to be taken, then a release of equal length.
  task automatic press_button();
    repeat (deb_len + 2) push_tick(1'b0, next_adc());
    repeat (deb_len + 2) push_tick(1'b1, next_adc());
  endtask

  // Button released except for short glitches that the debounce must reject.
  task automatic released_ticks(input int unsigned n, input int unsigned glitch_pct);
    int unsigned left;
    int unsigned glen;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < glitch_pct) begin
        glen = $urandom_range(1, (deb_len < 5) ? deb_len + 1 : 6);
        if (glen > left) glen = left;
        repeat (glen) push_tick(1'b0, next_adc());
        left -= glen;
      end else begin
        push_tick(1'b1, next_adc());
        left--;
      end
    end
  endtask

  // Returns once every queued tick has been accepted and answered.
  task automatic drain();
    while (tick_backlog_q.size() != 0 || in_valid || pending_status_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WARMUP:        warm_len   = TIMER_W'(val);
      CFG_DEBOUNCE:      deb_len    = TICKS_W'(val);
      CFG_READ_INTERVAL: intv_len   = TICKS_W'(val);
      CFG_CALIB_SPACING: space_len  = TICKS_W'(val);
      CFG_ALERT_MARGIN:  alert_len  = MARGIN_W'(val);
      CFG_NORMAL_MARGIN: normal_len = MARGIN_W'(val);
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic program_settings(input int unsigned warm, input int unsigned deb,
                                  input int unsigned intv, input int unsigned spacing,
                                  input int unsigned alert, input int unsigned normal);
    write_reg(CFG_WARMUP, warm);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_READ_INTERVAL, intv);
    write_reg(CFG_CALIB_SPACING, spacing);
    write_reg(CFG_ALERT_MARGIN, alert);
    write_reg(CFG_NORMAL_MARGIN, normal);
  endtask

  // Presses until the power state is the wanted one. Calibration ignores the
  // button, so it is run out first.
  task automatic set_power(input logic want);
    while (pw != want) begin
      if (ph == PHASE_CAL) begin
        released_ticks(32, 0);
      end else begin
        press_button();
      end
      drain();
    end
  endtask

  // One full run: warm-up, calibration and one measuring block, sometimes
  // cut short by a press.
  task automatic random_session(input logic allow_break);
    int unsigned alert;
    int unsigned n;
    alert = $urandom_range(0, 1200);
    program_settings($urandom_range(0, 20), $urandom_range(0, 4), $urandom_range(0, 2),
                     $urandom_range(0, 1), alert, $urandom_range(0, alert));
    set_power(1'b0);
    set_power(1'b1);
    n = warm_len + 101 * ((space_len == '0) ? 1 : space_len)
        + AVG_N * ((intv_len == '0) ? 1 : intv_len) + 10;
    released_ticks(n, 3);
    if (allow_break) begin
      press_button();
      released_ticks(20, 0);
    end
    drain();
  endtask

  // Tick driver. Ticks go out in bursts of random length separated by random
  // gaps; a gap of zero gives stretches of back-to-back transactions. Each
  // accepted tick is fed to the model at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    logic                  nxt_valid;
    logic [IN_TDATA_W-1:0] nxt_data;
    sensor_tick_t          t;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && s_axis_tready) begin
        pending_status_q.push_back(advance_monitor_tick(in_data[0], in_data[ADC_W:1]));
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_backlog_q.size() > 0) begin
          t         = tick_backlog_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = {{(IN_TDATA_W - ADC_W - 1){1'b0}}, t.adc, t.btn};
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // Result monitor. The ready pattern switches at random between always ready,
  // coin flips, mostly stalled and a fixed square wave.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t want;
    logic    rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && out_ready) begin
        if (pending_status_q.size() == 0) begin
          $display("%0t ns: status transaction with none expected, tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          bad_status_cnt++;
        end else begin
          want = pending_status_q.pop_front();
          check_field("lamp_code", want.lamp_code, m_axis_tdata[1:0]);
          check_field("run_phase", want.run_phase, m_axis_tdata[3:2]);
          check_field("alert_now", want.alert_now, m_axis_tdata[4]);
          check_field("scaled_difference", want.scaled_difference,
                      m_axis_tdata[DIFF_OUT_W+4:5]);
          check_field("verdict_valid", want.verdict_valid, m_axis_tuser);
        end
      end
      if (stall_len == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_len  = $urandom_range(8, 64);
      end else begin
        stall_len--;
      end
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = cycle_cnt[2];
      endcase
      out_ready <= rdy;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Model state and registers as they come out of reset.
    warm_len   = WARMUP_RST;
    deb_len    = DEBOUNCE_RST;
    intv_len   = INTERVAL_RST;
    space_len  = SPACING_RST;
    alert_len  = MARGIN_W'(ALERT_MARGIN_RST);
    normal_len = MARGIN_W'(NORMAL_MARGIN_RST);
    pw         = 1'b0;
    ph         = PHASE_OFF;
    stab_btn   = 1'b1;
    prev_btn   = 1'b1;
    deb_cnt    = '0;
    ph_timer   = '0;
    smp_cnt    = '0;
    smp_sum    = '0;
    base_sum   = '0;
    alarm      = 1'b0;
    lamp       = LAMP_DARK;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed opening with every register at zero: no debounce, so a
    // two-tick press powers up; no warm-up, so calibration starts on the
    // power-on tick; zero spacing acts as one; zero interval samples every
    // tick; zero margins alert on any difference and never clear.
    program_settings(0, 0, 0, 0, 0, 0);
    push_tick(1'b1, '0);
    push_tick(1'b0, ADC_W'(ADC_MAX));
    push_tick(1'b0, '0);
    // Button activity while calibrating must be ignored.
    push_tick(1'b1, ADC_W'(ADC_MAX));
    push_tick(1'b0, ADC_W'(ADC_MAX));
    push_tick(1'b0, 10'h155);
    push_tick(1'b1, 10'h2AA);
    for (int i = 0; i < 16; i++)
      push_tick(1'($urandom_range(0, 1)), (i % 2) ? ADC_W'(ADC_MAX) : '0);
    // Through calibration into measuring at the zero settings.
    released_ticks(160, 0);
    drain();

    // Reset margins with a short warm-up, so the hysteresis sees real swings.
    program_settings(5, 2, 1, 1, ALERT_MARGIN_RST, NORMAL_MARGIN_RST);
    set_power(1'b0);
    set_power(1'b1);
    released_ticks(220, 2);
    drain();

    // Every register at its top value. Button noise can no longer toggle
    // power, and no block mean can exceed the largest alert margin.
    program_settings(22'h3FFFFF, 1023, 1023, 1023, 16383, 16383);
    released_ticks(40, 10);
    drain();

    random_session(1'b1);

    if (bad_status_cnt == 0 && pending_status_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
